FILE: rtl/core/split_attention_lse_combine_assert.svh
// Assertion helpers for the split attention combine block.
// Both expect clk and rst_n in the scope where they are used.
`ifndef SPLIT_ATTENTION_LSE_COMBINE_ASSERT_SVH
`define SPLIT_ATTENTION_LSE_COMBINE_ASSERT_SVH

// Same-cycle implication.
`define SALC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("split_attention_lse_combine: assertion failed");

// Next-cycle implication.
`define SALC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("split_attention_lse_combine: assertion failed");

`endif

FILE: rtl/core/salc_pkg.sv
`default_nettype none

package salc_pkg;

  localparam int VAL_W   = 16;
  localparam int LSE_W   = 24;
  localparam int DEN_W   = 22;
  localparam int WGT_W   = 17;
  localparam int ACC_W   = 40;
  localparam int LN_W    = 19;
  localparam int EXP_W   = 31;
  localparam int EXP_D_W = 20;
  localparam int IDX_W   = 6;
  localparam int HD_W    = 7;
  localparam int NS_W    = 5;
  localparam int CFG_DATA_W = 7;
  localparam int CFG_IDX_W  = 1;

  localparam int EXP_STEPS = 20;

  // exp(-2^(j-16)) in Q30, one factor per bit of the argument.
  localparam logic [29:0] EXP_TAB [EXP_STEPS] = '{
    30'd1073725440, 30'd1073709056, 30'd1073676290, 30'd1073610760, 30'd1073479712,
    30'd1073217664, 30'd1072693760, 30'd1071646719, 30'd1069555701, 30'd1065385899,
    30'd1057095000, 30'd1040706261, 30'd1008687096, 30'd947573834,  30'd836230973,
    30'd651257337,  30'd395007542,  30'd145315154,  30'd19666268,   30'd360200
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HEAD_DIM   = 1'd0,
    REG_NUM_SPLITS = 1'd1
  } cfg_reg_t;

endpackage

`default_nettype wire

FILE: rtl/core/salc_in_if.sv
`default_nettype none

interface salc_in_if;
  import salc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  value;
  logic signed [LSE_W-1:0]  split_lse;
  logic                     lse_finite;
  logic                     split_enabled;

  modport source (output valid, value, split_lse, lse_finite, split_enabled, input ready);
  modport sink   (input valid, value, split_lse, lse_finite, split_enabled, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/salc_out_if.sv
`default_nettype none

interface salc_out_if;
  import salc_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [VAL_W-1:0]  out_value;
  logic signed [LSE_W-1:0]  combined_lse;
  logic                     lse_neg_inf;
  logic [IDX_W-1:0]         element_index;
  logic                     last;

  modport source (output valid, out_value, combined_lse, lse_neg_inf, element_index, last,
                  input ready);
  modport sink   (input valid, out_value, combined_lse, lse_neg_inf, element_index, last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/core/salc_cfg_if.sv
`default_nettype none

interface salc_cfg_if;
  import salc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/split_attention_lse_combine.sv
// Combines the partial attention outputs of several key splits into one row.
// in_chan carries one element per request, split-major and element-minor, with
// the split's lse and its two validity bits (sampled on element 0 only).
// out_chan returns one combined element per request of the last split of a row;
// the other requests give no result. cfg_chan writes head_dim (index 0) and
// num_splits (index 1); it is always ready and takes effect at once.
// An ordinary element passes through a multiply and an accumulate state; the
// first element of a split first opens it in S_START, and when exp(-d) must be
// formed it also takes 20 steps of the shared exp multiplier. On the last split
// the result adds a bit-serial division, and the first element that needs
// ln(denom) adds a log search (19 trial bits, each a full 20-step exp) once per row.
// The accumulator memory is read in the cycle after accept and written back once.
// Reset (synchronous, rst_n low) clears the element and split counters and row state and sets
// head_dim to 64 and num_splits to 16; the accumulator memory is not cleared.
// A finished result sits in the output register; the block takes the next
// request meanwhile and only waits if a second result is ready before the
// receiver takes the first.
`default_nettype none

module split_attention_lse_combine #(
  parameter int MAX_HEAD_DIM = 64,
  parameter int MAX_SPLITS   = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  salc_in_if.sink       in_chan,
  salc_out_if.source    out_chan,
  salc_cfg_if.sink      cfg_chan
);
  import salc_pkg::*;

  localparam int EC_W = (MAX_HEAD_DIM > 1) ? $clog2(MAX_HEAD_DIM) : 1;
  localparam int SC_W = (MAX_SPLITS > 1) ? $clog2(MAX_SPLITS) : 1;
  localparam logic [10:0] HD_MAX = 11'(MAX_HEAD_DIM);
  localparam logic [9:0]  NS_MAX = 10'(MAX_SPLITS);
  localparam logic [WGT_W-1:0] ONE_Q16 = WGT_W'(65536);
  localparam logic [DEN_W-1:0] DEN_ONE = DEN_W'(65536);
  localparam logic [DEN_W-1:0] DEN_SAT = {DEN_W{1'b1}};
  localparam logic [24:0] EXP_LIMIT = 25'(12 * 65536);

  typedef enum logic [10:0] {
    S_IDLE    = 11'b000_0000_0001,
    S_START   = 11'b000_0000_0010,
    S_EXP     = 11'b000_0000_0100,
    S_EXPFIN  = 11'b000_0000_1000,
    S_MUL     = 11'b000_0001_0000,
    S_ACC     = 11'b000_0010_0000,
    S_LN_SET  = 11'b000_0100_0000,
    S_LN_CMP  = 11'b000_1000_0000,
    S_DIV_SET = 11'b001_0000_0000,
    S_DIV     = 11'b010_0000_0000,
    S_EMIT    = 11'b100_0000_0000
  } state_t;

  // Control and row state.
  state_t                    state_r, state_nxt;
  logic [HD_W-1:0]           head_dim_r, head_dim_nxt;
  logic [NS_W-1:0]           num_splits_r, num_splits_nxt;
  logic [EC_W-1:0]           ec_r, ec_nxt;
  logic [SC_W-1:0]           sc_r, sc_nxt;
  logic                      any_r, any_nxt;
  logic [DEN_W-1:0]          denom_r, denom_nxt;
  logic signed [LSE_W-1:0]   max_r, max_nxt;
  logic [WGT_W-1:0]          scale_r, scale_nxt;
  logic [WGT_W-1:0]          w_r, w_nxt;
  logic                      ln_valid_r, ln_valid_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Request payload.
  logic signed [VAL_W-1:0]   val_r, val_nxt;
  logic signed [LSE_W-1:0]   lse_r, lse_nxt;
  logic                      sv_r, sv_nxt;

  // Shared exp unit.
  logic [EXP_W-1:0]          exp_r, exp_nxt;
  logic [EXP_D_W-1:0]        exp_d_r, exp_d_nxt;
  logic [4:0]                exp_j_r, exp_j_nxt;
  logic                      exp_ln_r, exp_ln_nxt;
  logic                      exp_zero_r, exp_zero_nxt;
  logic                      gt_r, gt_nxt;

  // Multiply-accumulate.
  logic signed [57:0]        p_old_r, p_old_nxt;
  logic signed [33:0]        p_new_r, p_new_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic signed [ACC_W-1:0]   rd_r;

  // Log search and divider.
  logic [LN_W-1:0]           ln_r, ln_nxt;
  logic [4:0]                lnb_r, lnb_nxt;
  logic [DEN_W-1:0]          rem_r, rem_nxt;
  logic [15:0]               nlo_r, nlo_nxt;
  logic [15:0]               q_r, q_nxt;
  logic [3:0]                dcnt_r, dcnt_nxt;
  logic                      qsat_r, qsat_nxt;
  logic                      zero_r, zero_nxt;
  logic [IDX_W-1:0]          eidx_r, eidx_nxt;
  logic                      elast_r, elast_nxt;

  // Output register.
  logic signed [VAL_W-1:0]   ov_r, ov_nxt;
  logic signed [LSE_W-1:0]   cl_r, cl_nxt;
  logic                      ninf_r, ninf_nxt;
  logic [IDX_W-1:0]          oidx_r, oidx_nxt;
  logic                      olast_r, olast_nxt;

  logic signed [ACC_W-1:0]   acc_mem [MAX_HEAD_DIM];
  logic                      mem_we;

  logic                      in_fire, out_fire, cfg_fire;
  logic [10:0]               hd_eff;
  logic [9:0]                ns_eff;
  logic                      last_elem, last_split;
  logic                      any_eff;
  logic [DEN_W-1:0]          denom_eff;
  logic signed [LSE_W-1:0]   max_eff;
  logic signed [LSE_W:0]     lse_diff;
  logic [LSE_W:0]            d_abs;
  logic                      start_gt;
  logic [60:0]               exp_prod;
  logic [60:0]               exp_rnd;
  logic [EXP_W:0]            exp_q16_sum;
  logic [WGT_W-1:0]          exp_q16;
  logic [38:0]               dmul;
  logic [39:0]               dmul_rnd;
  logic [24:0]               d_resc;
  logic [23:0]               d_add;
  logic signed [ACC_W-1:0]   old_m;
  logic signed [57:0]        p_rnd;
  logic signed [ACC_W-1:0]   acc_new;
  logic [LN_W-1:0]           ln_cand;
  logic [52:0]               ln_prod;
  logic [ACC_W-1:0]          mag;
  logic [ACC_W:0]            num;
  logic                      dsat;
  logic [DEN_W:0]            dtrial;
  logic                      dge;
  logic [EC_W+IDX_W-1:0]     ec_ext;
  logic signed [VAL_W:0]     q_neg;
  logic signed [25:0]        cl_sum;
  logic signed [VAL_W-1:0]   ov_fin;
  logic signed [LSE_W-1:0]   cl_fin;

  assign in_fire  = in_chan.valid && in_chan.ready;
  assign out_fire = out_chan.valid && out_chan.ready;
  assign cfg_fire = cfg_chan.valid && cfg_chan.ready;

  assign in_chan.ready  = (state_r == S_IDLE);
  assign cfg_chan.ready = 1'b1;

  assign out_chan.valid         = out_valid_r;
  assign out_chan.out_value     = ov_r;
  assign out_chan.combined_lse  = cl_r;
  assign out_chan.lse_neg_inf   = ninf_r;
  assign out_chan.element_index = oidx_r;
  assign out_chan.last          = olast_r;

  // Register bounds: zero acts as one, values past the build limit are clamped.
  assign hd_eff = (head_dim_r == '0) ? 11'd1 :
                  ((11'(head_dim_r) > HD_MAX) ? HD_MAX : 11'(head_dim_r));
  assign ns_eff = (num_splits_r == '0) ? 10'd1 :
                  ((10'(num_splits_r) > NS_MAX) ? NS_MAX : 10'(num_splits_r));
  assign last_elem  = (11'(ec_r) + 11'd1) >= hd_eff;
  assign last_split = (10'(sc_r) + 10'd1) >= ns_eff;
  assign ec_ext     = (EC_W + IDX_W)'(ec_r);

  // The first split of a row starts from a cleared maximum and denominator.
  assign any_eff   = (sc_r == '0) ? 1'b0 : any_r;
  assign denom_eff = (sc_r == '0) ? '0 : denom_r;
  assign max_eff   = (sc_r == '0) ? '0 : max_r;
  assign lse_diff  = (LSE_W + 1)'(lse_r) - (LSE_W + 1)'(max_eff);
  assign start_gt  = lse_r > max_eff;
  assign d_abs     = start_gt ? lse_diff : -lse_diff;

  // One table factor per cycle, rounded half up in Q30.
  assign exp_prod    = 61'(exp_r) * 61'(EXP_TAB[exp_j_r]);
  assign exp_rnd     = exp_prod + 61'(1 << 29);
  assign exp_q16_sum = (EXP_W + 1)'(exp_r) + (EXP_W + 1)'(8192);
  assign exp_q16     = exp_zero_r ? '0 : exp_q16_sum[30:14];

  // Denominator rescale or add, saturated to its register width.
  assign dmul     = 39'(denom_r) * 39'(exp_q16);
  assign dmul_rnd = 40'(dmul) + 40'd32768;
  assign d_resc   = 25'(dmul_rnd[39:16]) + 25'd65536;
  assign d_add    = 24'(denom_r) + 24'(exp_q16);

  assign old_m   = (scale_r != '0) ? rd_r : '0;
  assign p_rnd   = p_old_r + 58'sd32768;
  assign acc_new = ACC_W'(p_rnd >>> 16) + ACC_W'(p_new_r);

  assign ln_cand = ln_r | (LN_W'(1) << lnb_r);
  assign ln_prod = 53'(exp_r) * 53'(denom_r);

  // Rounded magnitude division: numerator plus half the divisor.
  assign mag    = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : acc_r;
  assign num    = (ACC_W + 1)'(mag) + (ACC_W + 1)'(denom_r >> 1);
  assign dsat   = num >= (ACC_W + 1)'({denom_r, 16'b0});
  assign dtrial = {rem_r, nlo_r[15]};
  assign dge    = dtrial >= {1'b0, denom_r};

  assign q_neg  = -$signed({1'b0, q_r});
  assign cl_sum = 26'(max_r) + $signed({7'b0, ln_r});

  always_comb begin
    if (zero_r) begin
      ov_fin = '0;
    end else if (acc_r[ACC_W-1]) begin
      ov_fin = (qsat_r || (q_r > 16'd32768)) ? 16'sh8000 : VAL_W'(q_neg);
    end else begin
      ov_fin = (qsat_r || (q_r > 16'd32767)) ? 16'sh7fff : $signed(q_r);
    end
    if (zero_r) begin
      cl_fin = '0;
    end else if (cl_sum > 26'sd8388607) begin
      cl_fin = 24'sh7fffff;
    end else if (cl_sum < -26'sd8388608) begin
      cl_fin = 24'sh800000;
    end else begin
      cl_fin = LSE_W'(cl_sum);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    head_dim_nxt   = head_dim_r;
    num_splits_nxt = num_splits_r;
    ec_nxt         = ec_r;
    sc_nxt         = sc_r;
    any_nxt        = any_r;
    denom_nxt      = denom_r;
    max_nxt        = max_r;
    scale_nxt      = scale_r;
    w_nxt          = w_r;
    ln_valid_nxt   = ln_valid_r;
    out_valid_nxt  = out_valid_r;
    val_nxt        = val_r;
    lse_nxt        = lse_r;
    sv_nxt         = sv_r;
    exp_nxt        = exp_r;
    exp_d_nxt      = exp_d_r;
    exp_j_nxt      = exp_j_r;
    exp_ln_nxt     = exp_ln_r;
    exp_zero_nxt   = exp_zero_r;
    gt_nxt         = gt_r;
    p_old_nxt      = p_old_r;
    p_new_nxt      = p_new_r;
    acc_nxt        = acc_r;
    ln_nxt         = ln_r;
    lnb_nxt        = lnb_r;
    rem_nxt        = rem_r;
    nlo_nxt        = nlo_r;
    q_nxt          = q_r;
    dcnt_nxt       = dcnt_r;
    qsat_nxt       = qsat_r;
    zero_nxt       = zero_r;
    eidx_nxt       = eidx_r;
    elast_nxt      = elast_r;
    ov_nxt         = ov_r;
    cl_nxt         = cl_r;
    ninf_nxt       = ninf_r;
    oidx_nxt       = oidx_r;
    olast_nxt      = olast_r;
    mem_we         = 1'b0;

    if (out_fire) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_chan.index))
        REG_HEAD_DIM:   head_dim_nxt   = cfg_chan.data;
        REG_NUM_SPLITS: num_splits_nxt = cfg_chan.data[NS_W-1:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          val_nxt   = in_chan.value;
          lse_nxt   = in_chan.split_lse;
          sv_nxt    = in_chan.lse_finite && in_chan.split_enabled;
          state_nxt = (ec_r == '0) ? S_START : S_MUL;
        end
      end
      S_START: begin
        ln_valid_nxt = 1'b0;
        if (sv_r && !any_eff) begin
          // First contributing split of the row sets the reference maximum.
          max_nxt   = lse_r;
          scale_nxt = '0;
          w_nxt     = ONE_Q16;
          denom_nxt = DEN_ONE;
          any_nxt   = 1'b1;
          state_nxt = S_MUL;
        end else if (sv_r) begin
          gt_nxt       = start_gt;
          exp_zero_nxt = d_abs >= EXP_LIMIT;
          exp_d_nxt    = d_abs[EXP_D_W-1:0];
          exp_nxt      = EXP_W'(1 << 30);
          exp_j_nxt    = '0;
          exp_ln_nxt   = 1'b0;
          state_nxt    = S_EXP;
        end else begin
          // A masked split leaves the sums and only carries the old entries over.
          scale_nxt = any_eff ? ONE_Q16 : '0;
          w_nxt     = '0;
          any_nxt   = any_eff;
          denom_nxt = denom_eff;
          max_nxt   = max_eff;
          state_nxt = S_MUL;
        end
      end
      S_EXP: begin
        if (exp_d_r[exp_j_r]) begin
          exp_nxt = exp_rnd[60:30];
        end
        exp_j_nxt = exp_j_r + 5'd1;
        if (exp_j_r == 5'(EXP_STEPS - 1)) begin
          state_nxt = exp_ln_r ? S_LN_CMP : S_EXPFIN;
        end
      end
      S_EXPFIN: begin
        if (gt_r) begin
          // New maximum: shrink what was summed so far.
          scale_nxt = exp_q16;
          w_nxt     = ONE_Q16;
          denom_nxt = (d_resc > 25'(DEN_SAT)) ? DEN_SAT : d_resc[DEN_W-1:0];
          max_nxt   = lse_r;
        end else begin
          scale_nxt = ONE_Q16;
          w_nxt     = exp_q16;
          denom_nxt = (d_add > 24'(DEN_SAT)) ? DEN_SAT : d_add[DEN_W-1:0];
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        p_old_nxt = old_m * $signed({1'b0, scale_r});
        p_new_nxt = val_r * $signed({1'b0, w_r});
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = acc_new;
        mem_we    = 1'b1;
        eidx_nxt  = ec_ext[IDX_W-1:0];
        elast_nxt = last_elem;
        if (last_elem) begin
          ec_nxt = '0;
          sc_nxt = last_split ? '0 : sc_r + SC_W'(1);
        end else begin
          ec_nxt = ec_r + EC_W'(1);
        end
        if (!last_split) begin
          state_nxt = S_IDLE;
        end else if (any_r && (denom_r != '0)) begin
          zero_nxt = 1'b0;
          if (ln_valid_r) begin
            state_nxt = S_DIV_SET;
          end else begin
            ln_nxt    = '0;
            lnb_nxt   = 5'(LN_W - 1);
            state_nxt = S_LN_SET;
          end
        end else begin
          zero_nxt  = 1'b1;
          state_nxt = S_EMIT;
        end
      end
      S_LN_SET: begin
        exp_d_nxt  = EXP_D_W'(ln_cand);
        exp_nxt    = EXP_W'(1 << 30);
        exp_j_nxt  = '0;
        exp_ln_nxt = 1'b1;
        state_nxt  = S_EXP;
      end
      S_LN_CMP: begin
        // Keep the trial bit while exp(-L) * denom still reaches one.
        if (ln_prod[52:46] != '0) begin
          ln_nxt = ln_cand;
        end
        if (lnb_r == '0) begin
          ln_valid_nxt = 1'b1;
          state_nxt    = S_DIV_SET;
        end else begin
          lnb_nxt   = lnb_r - 5'd1;
          state_nxt = S_LN_SET;
        end
      end
      S_DIV_SET: begin
        qsat_nxt = dsat;
        rem_nxt  = num[DEN_W+15:16];
        nlo_nxt  = num[15:0];
        q_nxt    = '0;
        dcnt_nxt = '0;
        state_nxt = dsat ? S_EMIT : S_DIV;
      end
      S_DIV: begin
        rem_nxt  = dge ? DEN_W'(dtrial - {1'b0, denom_r}) : dtrial[DEN_W-1:0];
        q_nxt    = {q_r[14:0], dge};
        nlo_nxt  = {nlo_r[14:0], 1'b0};
        dcnt_nxt = dcnt_r + 4'd1;
        if (dcnt_r == 4'd15) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_chan.ready) begin
          ov_nxt        = ov_fin;
          cl_nxt        = cl_fin;
          ninf_nxt      = zero_r;
          oidx_nxt      = eidx_r;
          olast_nxt     = elast_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      head_dim_r   <= HD_W'(64);
      num_splits_r <= NS_W'(16);
      ec_r         <= '0;
      sc_r         <= '0;
      any_r        <= 1'b0;
      denom_r      <= '0;
      max_r        <= '0;
      scale_r      <= '0;
      w_r          <= '0;
      ln_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_dim_r   <= head_dim_nxt;
      num_splits_r <= num_splits_nxt;
      ec_r         <= ec_nxt;
      sc_r         <= sc_nxt;
      any_r        <= any_nxt;
      denom_r      <= denom_nxt;
      max_r        <= max_nxt;
      scale_r      <= scale_nxt;
      w_r          <= w_nxt;
      ln_valid_r   <= ln_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r      <= val_nxt;
    lse_r      <= lse_nxt;
    sv_r       <= sv_nxt;
    exp_r      <= exp_nxt;
    exp_d_r    <= exp_d_nxt;
    exp_j_r    <= exp_j_nxt;
    exp_ln_r   <= exp_ln_nxt;
    exp_zero_r <= exp_zero_nxt;
    gt_r       <= gt_nxt;
    p_old_r    <= p_old_nxt;
    p_new_r    <= p_new_nxt;
    acc_r      <= acc_nxt;
    ln_r       <= ln_nxt;
    lnb_r      <= lnb_nxt;
    rem_r      <= rem_nxt;
    nlo_r      <= nlo_nxt;
    q_r        <= q_nxt;
    dcnt_r     <= dcnt_nxt;
    qsat_r     <= qsat_nxt;
    zero_r     <= zero_nxt;
    eidx_r     <= eidx_nxt;
    elast_r    <= elast_nxt;
    ov_r       <= ov_nxt;
    cl_r       <= cl_nxt;
    ninf_r     <= ninf_nxt;
    oidx_r     <= oidx_nxt;
    olast_r    <= olast_nxt;
  end

  // Accumulator memory: one port, read every cycle at the current element.
  // Requests are handled one at a time, so a write always lands before the
  // next read of the same entry.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      acc_mem[ec_r] <= acc_new;
    end
    rd_r <= acc_mem[ec_r];
  end

`include "split_attention_lse_combine_assert.svh"

  `SALC_ASSERT_IMP(a_div_rem_below_den, state_r == S_DIV, rem_r < denom_r)
  `SALC_ASSERT_IMP(a_emit_needs_ln, (state_r == S_EMIT) && !zero_r, ln_valid_r)
  `SALC_ASSERT_NXT(a_ln_search_done, (state_r == S_LN_CMP) && (lnb_r == '0), ln_valid_r)
  `SALC_ASSERT_IMP(a_result_from_emit, $rose(out_valid_r), $past(state_r == S_EMIT))

endmodule

`default_nettype wire
